// ===== rtl/core/cfp_pkg.sv =====
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared constants for the command frame parser: frame bytes, function and
// command codes, parse phases and event codes.
// ----------------------------------------------------------------------------
package cfp_pkg;

	// Field widths.
	localparam int BYTE_W   = 8;
	localparam int EVENT_W  = 4;
	localparam int TARGET_W = 16;
	localparam int NUM_TGT  = 4;
	localparam int IDX_W    = 5;
	localparam int PHASE_W  = 3;

	// Frame bytes and codes.
	localparam logic [BYTE_W-1:0] HDR_FIRST   = 8'hAA;
	localparam logic [BYTE_W-1:0] HDR_SECOND  = 8'hAF;
	localparam logic [BYTE_W-1:0] FN_COMMAND  = 8'h01;
	localparam logic [BYTE_W-1:0] FN_SET2     = 8'h02;
	localparam logic [BYTE_W-1:0] FN_CONTROL  = 8'h03;
	localparam logic [BYTE_W-1:0] FN_PID      = 8'h10;
	localparam logic [BYTE_W-1:0] CMD_ACC     = 8'h01;
	localparam logic [BYTE_W-1:0] CMD_GYRO    = 8'h02;
	localparam logic [BYTE_W-1:0] CMD_MAG     = 8'h04;
	localparam logic [BYTE_W-1:0] CMD_LOCK    = 8'hA0;
	localparam logic [BYTE_W-1:0] CMD_UNLOCK  = 8'hA1;
	localparam logic [BYTE_W-1:0] REPLY_FN    = 8'hEF;
	localparam logic [BYTE_W-1:0] LEN_COMMAND = 8'd1;
	localparam logic [BYTE_W-1:0] LEN_CONTROL = 8'd20;

	// Number of leading payload bytes that carry the four targets.
	localparam logic [IDX_W-1:0] TGT_BYTES = 5'd8;

	// Sum of the fixed bytes of the reply frame: AA AA EF 02 01.
	localparam int REPLY_FIXED_SUM_I = 'hAA + 'hAA + 'hEF + 'h02 + 'h01;
	localparam logic [BYTE_W-1:0] REPLY_FIXED_SUM = REPLY_FIXED_SUM_I[BYTE_W-1:0];

	// Parse phases.
	localparam logic [PHASE_W-1:0] PH_HUNT  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_HDR2  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_FUNC  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_LEN   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_DATA  = 3'd4;
	localparam logic [PHASE_W-1:0] PH_CHECK = 3'd5;

	// Event codes.
	localparam logic [EVENT_W-1:0] EV_ACC      = 4'd0;
	localparam logic [EVENT_W-1:0] EV_GYRO     = 4'd1;
	localparam logic [EVENT_W-1:0] EV_MAG      = 4'd2;
	localparam logic [EVENT_W-1:0] EV_LOCKED   = 4'd3;
	localparam logic [EVENT_W-1:0] EV_UNLOCKED = 4'd4;
	localparam logic [EVENT_W-1:0] EV_CONTROL  = 4'd5;
	localparam logic [EVENT_W-1:0] EV_NOACTION = 4'd6;
	localparam logic [EVENT_W-1:0] EV_UNK_CMD  = 4'd7;
	localparam logic [EVENT_W-1:0] EV_SUM_ERR  = 4'd8;
	localparam logic [EVENT_W-1:0] EV_UNK_FUNC = 4'd9;
	localparam logic [EVENT_W-1:0] EV_LEN_ERR  = 4'd10;

endpackage

// ===== rtl/core/command_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// command_frame_parser_core
// Byte-serial command frame receiver: header hunt, function, length, payload
// and checksum, with lock state and committed flight targets.
// ----------------------------------------------------------------------------
// The parser takes one received byte per clock cycle while the input is not
// stalled: a byte is registered on acceptance in the input register, parsed by
// the frame state machine while it is held there and, if it completes a frame
// or raises an error, the event is captured in the result register. Most bytes
// give no result. The input is stalled only while a byte is held and the
// result register is full and itself stalled.
// Every result carries the current lock flag and the last committed targets;
// lock and unlock commands also raise a reply request with the echoed
// checksum and the sum of the reply frame.
module command_frame_parser_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input channel.
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [cfp_pkg::BYTE_W-1:0]         rx_byte,
	// Result channel.
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [cfp_pkg::EVENT_W-1:0]        event_res,
	output logic                               locked,
	output logic [cfp_pkg::TARGET_W-1:0]       throttle_target,
	output logic [cfp_pkg::TARGET_W-1:0]       yaw_target,
	output logic [cfp_pkg::TARGET_W-1:0]       roll_target,
	output logic [cfp_pkg::TARGET_W-1:0]       pitch_target,
	output logic                               reply_needed,
	output logic [cfp_pkg::BYTE_W-1:0]         reply_check,
	output logic [cfp_pkg::BYTE_W-1:0]         reply_frame_sum
);
	import cfp_pkg::*;

	// Input stage.
	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                advance;

	// Parser state.
	logic [PHASE_W-1:0]  phase_q, phase_nxt;
	logic [BYTE_W-1:0]   func_q, func_nxt;
	logic [BYTE_W-1:0]   len_q, len_nxt;
	logic [IDX_W-1:0]    idx_q, idx_nxt;
	logic [BYTE_W-1:0]   sum_q, sum_nxt;
	logic [BYTE_W-1:0]   cmd_q, cmd_nxt;
	logic [TARGET_W-1:0] shadow_q [NUM_TGT];
	logic [TARGET_W-1:0] shadow_nxt [NUM_TGT];
	logic [TARGET_W-1:0] commit_q [NUM_TGT];
	logic [TARGET_W-1:0] commit_nxt [NUM_TGT];
	logic                lock_q, lock_nxt;

	// Result of the byte being parsed.
	logic                res_valid;
	logic [EVENT_W-1:0]  res_event;
	logic                res_reply;
	logic [BYTE_W-1:0]   res_check;
	logic [8:0]          last_pos;

	// Result register.
	logic                out_valid_q;
	logic [EVENT_W-1:0]  event_q;
	logic                locked_q;
	logic [TARGET_W-1:0] tgt_q [NUM_TGT];
	logic                reply_q;
	logic [BYTE_W-1:0]   check_q;
	logic [BYTE_W-1:0]   frame_sum_q;

	// The held byte is parsed whenever the result register can take a result.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// Position of the current payload byte counted from one, against the length.
	assign last_pos = {4'd0, idx_q} + 9'd1;

	// Frame state machine for one byte.
	always_comb begin
		phase_nxt  = phase_q;
		func_nxt   = func_q;
		len_nxt    = len_q;
		idx_nxt    = idx_q;
		sum_nxt    = sum_q;
		cmd_nxt    = cmd_q;
		shadow_nxt = shadow_q;
		commit_nxt = commit_q;
		lock_nxt   = lock_q;
		res_valid  = 1'b0;
		res_event  = EV_NOACTION;
		res_reply  = 1'b0;
		res_check  = '0;
		case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == HDR_FIRST) begin
					phase_nxt = PH_HDR2;
				end
			end
			PH_HDR2: begin
				if (byte_s1 == HDR_SECOND) begin
					phase_nxt = PH_FUNC;
				end else if (byte_s1 != HDR_FIRST) begin
					phase_nxt = PH_HUNT;
				end
			end
			PH_FUNC: begin
				if (byte_s1 inside {FN_COMMAND, FN_CONTROL}) begin
					func_nxt  = byte_s1;
					sum_nxt   = HDR_FIRST + HDR_SECOND + byte_s1;
					phase_nxt = PH_LEN;
				end else begin
					phase_nxt = PH_HUNT;
					res_valid = 1'b1;
					res_event = (byte_s1 inside {FN_SET2, FN_PID}) ? EV_NOACTION
						: EV_UNK_FUNC;
				end
			end
			PH_LEN: begin
				len_nxt = byte_s1;
				sum_nxt = sum_q + byte_s1;
				if ((func_q == FN_COMMAND && byte_s1 != LEN_COMMAND) ||
				    (func_q == FN_CONTROL && byte_s1 != LEN_CONTROL)) begin
					phase_nxt = PH_HUNT;
					res_valid = 1'b1;
					res_event = EV_LEN_ERR;
				end else begin
					idx_nxt   = '0;
					phase_nxt = PH_DATA;
				end
			end
			PH_DATA: begin
				sum_nxt = sum_q + byte_s1;
				if (func_q == FN_COMMAND) begin
					cmd_nxt = byte_s1;
				end else if (idx_q < TGT_BYTES) begin
					// Targets arrive big-endian, high byte first.
					if (!idx_q[0]) begin
						shadow_nxt[idx_q[2:1]][15:8] = byte_s1;
					end else begin
						shadow_nxt[idx_q[2:1]][7:0] = byte_s1;
					end
				end
				if (last_pos >= {1'b0, len_q}) begin
					phase_nxt = PH_CHECK;
				end
				idx_nxt = idx_q + IDX_W'(1);
			end
			PH_CHECK: begin
				phase_nxt = PH_HUNT;
				res_valid = 1'b1;
				if (byte_s1 != sum_q) begin
					res_event = EV_SUM_ERR;
				end else if (func_q == FN_CONTROL) begin
					commit_nxt = shadow_q;
					res_event  = EV_CONTROL;
				end else begin
					case (cmd_q)
						CMD_ACC:  res_event = EV_ACC;
						CMD_GYRO: res_event = EV_GYRO;
						CMD_MAG:  res_event = EV_MAG;
						CMD_LOCK: begin
							lock_nxt  = 1'b1;
							res_event = EV_LOCKED;
							res_reply = 1'b1;
							res_check = byte_s1;
						end
						CMD_UNLOCK: begin
							lock_nxt  = 1'b0;
							res_event = EV_UNLOCKED;
							res_reply = 1'b1;
							res_check = byte_s1;
						end
						default: res_event = EV_UNK_CMD;
					endcase
				end
			end
			default: begin
				phase_nxt = PH_HUNT;
			end
		endcase
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			func_q  <= '0;
			len_q   <= '0;
			idx_q   <= '0;
			sum_q   <= '0;
			cmd_q   <= '0;
			lock_q  <= 1'b1;
			for (int i = 0; i < NUM_TGT; i++) begin
				shadow_q[i] <= '0;
				commit_q[i] <= '0;
			end
		end else if (advance) begin
			phase_q  <= phase_nxt;
			func_q   <= func_nxt;
			len_q    <= len_nxt;
			idx_q    <= idx_nxt;
			sum_q    <= sum_nxt;
			cmd_q    <= cmd_nxt;
			lock_q   <= lock_nxt;
			shadow_q <= shadow_nxt;
			commit_q <= commit_nxt;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, showing the state as left by the byte.
	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			event_q     <= res_event;
			locked_q    <= lock_nxt;
			tgt_q       <= commit_nxt;
			reply_q     <= res_reply;
			check_q     <= res_check;
			frame_sum_q <= res_reply ? REPLY_FIXED_SUM + res_check : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign event_res       = event_q;
	assign locked          = locked_q;
	assign throttle_target = tgt_q[0];
	assign yaw_target      = tgt_q[1];
	assign roll_target     = tgt_q[2];
	assign pitch_target    = tgt_q[3];
	assign reply_needed    = reply_q;
	assign reply_check     = check_q;
	assign reply_frame_sum = frame_sum_q;

endmodule
